### rtl/core/fawr_pkg.sv
// Shared types, codes and constants for the frame admission whitelist filter.
`default_nettype none

package fawr_pkg;

    localparam int NODE_SLOTS_DEF     = 16;
    localparam int AUTH_TAG_BYTES_DEF = 32;
    localparam int HEADER_BYTES       = 9;

    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_SHORT   = 4'd1;
    localparam logic [3:0] ST_MAGIC   = 4'd2;
    localparam logic [3:0] ST_PAYLOAD = 4'd3;
    localparam logic [3:0] ST_TRUNC   = 4'd4;
    localparam logic [3:0] ST_UNKNOWN = 4'd5;
    localparam logic [3:0] ST_REPLAY  = 4'd6;
    localparam logic [3:0] ST_AUTH    = 4'd7;
    localparam logic [3:0] ST_FULL    = 4'd8;
    localparam logic [3:0] ST_ABSENT  = 4'd9;

    localparam logic [2:0] CFG_OWN_NODE_ID    = 3'd0;
    localparam logic [2:0] CFG_EXPECTED_MAGIC = 3'd1;
    localparam logic [2:0] CFG_PAYLOAD_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_ACK_TYPE_CODE  = 3'd3;
    localparam logic [2:0] CFG_JOIN_TYPE_CODE = 3'd4;

    localparam logic [7:0] PAYLOAD_LIMIT_RST = 8'd214;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] node_id;
        logic [7:0]  frame_length;
        logic [15:0] magic_word;
        logic [7:0]  sequence_req;
        logic [7:0]  message_type;
        logic [7:0]  payload_length;
        logic        auth_ok;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        ack_recorded;
        logic        join_added;
        logic [15:0] sender_rx_count;
    } out_item_t;

    // Request traveling down the cell row, with the result as it stands so far.
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] node_id;
        logic [7:0]  seq;
        logic        own;
        logic        pre_ok;
        logic        auth;
        logic        is_ack;
        logic        join_ok;
        logic        append_ok;
        logic        found;
        logic        appended;
        logic [3:0]  status;
        logic        ack_recorded;
        logic        join_added;
        logic [15:0] rx;
    } token_t;

endpackage

`default_nettype wire

### rtl/core/fawr_cell.sv
// One whitelist slot: holds an entry and acts on the request passing through.
`default_nettype none

module fawr_cell
    import fawr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire token_t tok_in,
    output token_t      tok_out
);

    logic        used_reg, used_next;
    logic        active_reg, active_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] rx_reg, rx_next;
    logic [15:0] id_reg, id_next;
    token_t      tok_reg, tok_next;
    logic        hit;
    logic        place;

    always_comb
    begin
        used_next   = used_reg;
        active_next = active_reg;
        seq_next    = seq_reg;
        rx_next     = rx_reg;
        id_next     = id_reg;
        tok_next    = tok_in;

        hit   = tok_in.valid && used_reg && !tok_in.found && (id_reg == tok_in.node_id);
        place = tok_in.valid && !used_reg && !tok_in.found && tok_in.append_ok;

        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.rx    = rx_reg;
            case (tok_in.kind)
                KIND_FRAME:
                begin
                    if (tok_in.pre_ok)
                    begin
                        tok_next.ack_recorded = 1'b0;
                        if (!tok_in.own && !active_reg)
                        begin
                            tok_next.status = ST_UNKNOWN;
                        end
                        else if (seq_reg == tok_in.seq)
                        begin
                            tok_next.status = ST_REPLAY;
                        end
                        else
                        begin
                            // advance sequence and count ahead of the auth verdict
                            seq_next    = tok_in.seq;
                            rx_next     = rx_reg + 16'd1;
                            tok_next.rx = rx_reg + 16'd1;
                            if (!tok_in.auth)
                            begin
                                tok_next.status = ST_AUTH;
                            end
                            else
                            begin
                                tok_next.status       = ST_OK;
                                tok_next.ack_recorded = tok_in.is_ack;
                                if (tok_in.join_ok)
                                begin
                                    active_next         = 1'b1;
                                    tok_next.join_added = 1'b1;
                                end
                            end
                        end
                    end
                end
                KIND_ADD:
                begin
                    if (tok_in.append_ok)
                    begin
                        active_next = 1'b1;
                    end
                end
                KIND_REMOVE:
                begin
                    active_next     = 1'b0;
                    tok_next.status = ST_OK;
                end
                default:
                begin
                    // unused kind reports no count
                    tok_next.rx = tok_in.rx;
                end
            endcase
        end

        // first free slot takes the new node
        if (place)
        begin
            used_next           = 1'b1;
            active_next         = 1'b1;
            id_next             = tok_in.node_id;
            tok_next.found      = 1'b1;
            tok_next.appended   = 1'b1;
            tok_next.join_added = (tok_in.kind == KIND_FRAME);
            tok_next.rx         = rx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= 1'b0;
            active_reg <= 1'b0;
            seq_reg    <= '0;
            rx_reg     <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            used_reg   <= used_next;
            active_reg <= active_next;
            seq_reg    <= seq_next;
            rx_reg     <= rx_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

### rtl/core/frame_admission_whitelist_replay.sv
// Top level of the frame admission filter: header checks, cell row, result register.
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+----------------------------
//  in      | in_valid, in_ready, in_item     | to block  | in_item_t request
//  out     | out_valid, out_ready, out_item  | from block| out_item_t result
//  cfg     | cfg_valid, cfg_ready, cfg_index,| to block  | register index, 16-bit data
//          | cfg_data                        |           |
//
// An accepted request moves through the row of slot cells one cell per cycle, then
// through a holding register into the output register. One request is in the row at a
// time; the next one is accepted once the previous result has left the holding register,
// also while that result still waits on out. Reset clears table and counters and returns
// the configuration registers to their reset values; cfg is always ready.
`default_nettype none

module frame_admission_whitelist_replay
    import fawr_pkg::*;
#(
    parameter int NODE_SLOTS     = NODE_SLOTS_DEF,
    parameter int AUTH_TAG_BYTES = AUTH_TAG_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CNT_W   = $clog2(NODE_SLOTS + 1);
    localparam int MIN_LEN = HEADER_BYTES + AUTH_TAG_BYTES;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] own_id_reg;
    logic [15:0] magic_reg;
    logic [7:0]  plimit_reg;
    logic [7:0]  ack_code_reg;
    logic [7:0]  join_code_reg;
    logic [CNT_W-1:0] used_cnt_reg;
    logic        ack_pending_reg;
    logic [7:0]  ack_seq_reg;
    token_t      pend_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;
    token_t      tok [NODE_SLOTS+1];
    token_t      entry;
    logic        in_fire;
    logic        move;
    logic        full;
    logic        is_ack;
    logic [9:0]  need_len;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign move      = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign full      = (used_cnt_reg == CNT_W'(NODE_SLOTS));

    always_comb
    begin
        is_ack   = (in_item.message_type == ack_code_reg);
        need_len = 10'(HEADER_BYTES) + {2'b00, in_item.payload_length}
                   + 10'(AUTH_TAG_BYTES);

        entry              = '0;
        entry.valid        = in_fire;
        entry.kind         = in_item.kind;
        entry.node_id      = in_item.node_id;
        entry.seq          = in_item.sequence_req;
        entry.own          = (in_item.node_id == own_id_reg);
        entry.auth         = in_item.auth_ok;
        entry.is_ack       = is_ack;
        entry.join_ok      = !is_ack && (in_item.message_type == join_code_reg) && !full;
        entry.pre_ok       = 1'b0;

        // result assuming the node is not in the table; a matching cell may override it
        case (in_item.kind)
            KIND_FRAME:
            begin
                if ({2'b00, in_item.frame_length} < 10'(MIN_LEN))
                    entry.status = ST_SHORT;
                else if (in_item.magic_word != magic_reg)
                    entry.status = ST_MAGIC;
                else if (in_item.payload_length > plimit_reg)
                    entry.status = ST_PAYLOAD;
                else if (need_len > {2'b00, in_item.frame_length})
                    entry.status = ST_TRUNC;
                else
                begin
                    entry.pre_ok = 1'b1;
                    if (!entry.own)
                        entry.status = ST_UNKNOWN;
                    else if (!in_item.auth_ok)
                        entry.status = ST_AUTH;
                    else
                    begin
                        entry.status       = ST_OK;
                        entry.ack_recorded = is_ack;
                        entry.append_ok    = entry.join_ok;
                    end
                end
            end
            KIND_ADD:
            begin
                entry.status    = full ? ST_FULL : ST_OK;
                entry.append_ok = !full;
            end
            KIND_REMOVE:
            begin
                entry.status = ST_ABSENT;
            end
            default:
            begin
                entry.status = ST_OK;
            end
        endcase
    end

    assign tok[0] = entry;

    for (genvar g = 0; g < NODE_SLOTS; g++)
    begin : g_cell
        fawr_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_RUN;
            S_RUN:  if (tok[NODE_SLOTS].valid) state_next = S_DONE;
            S_DONE: if (move) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            own_id_reg      <= '0;
            magic_reg       <= '0;
            plimit_reg      <= PAYLOAD_LIMIT_RST;
            ack_code_reg    <= '0;
            join_code_reg   <= '0;
            used_cnt_reg    <= '0;
            ack_pending_reg <= 1'b0;
            ack_seq_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_OWN_NODE_ID:    own_id_reg    <= cfg_data;
                    CFG_EXPECTED_MAGIC: magic_reg     <= cfg_data;
                    CFG_PAYLOAD_LIMIT:  plimit_reg    <= cfg_data[7:0];
                    CFG_ACK_TYPE_CODE:  ack_code_reg  <= cfg_data[7:0];
                    CFG_JOIN_TYPE_CODE: join_code_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (tok[NODE_SLOTS].valid)
            begin
                if (tok[NODE_SLOTS].appended)
                    used_cnt_reg <= used_cnt_reg + CNT_W'(1);
                if (tok[NODE_SLOTS].ack_recorded)
                begin
                    ack_pending_reg <= 1'b1;
                    ack_seq_reg     <= tok[NODE_SLOTS].seq;
                end
            end

            if (move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // hold the finished request until the output register is free
    always_ff @(posedge clk)
    begin
        if (tok[NODE_SLOTS].valid)
            pend_reg <= tok[NODE_SLOTS];
        if (move)
        begin
            out_reg.status          <= pend_reg.status;
            out_reg.ack_recorded    <= pend_reg.ack_recorded;
            out_reg.join_added      <= pend_reg.join_added;
            out_reg.sender_rx_count <= pend_reg.rx;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_cnt_reg <= CNT_W'(NODE_SLOTS))
        else $error("slot count beyond table size");

    a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tok[NODE_SLOTS].valid |-> state_reg == S_RUN)
        else $error("request left the cell row outside of RUN");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (tok[NODE_SLOTS].valid && tok[NODE_SLOTS].appended)
            |-> used_cnt_reg < CNT_W'(NODE_SLOTS))
        else $error("node appended to a full table");

    a_ack_record: assert property (@(posedge clk) disable iff (!rst_n)
        (tok[NODE_SLOTS].valid && tok[NODE_SLOTS].ack_recorded)
            |=> ack_pending_reg && ack_seq_reg == $past(tok[NODE_SLOTS].seq))
        else $error("acknowledgement not recorded");

endmodule

`default_nettype wire

### sim/frame_admission_whitelist_replay_test.sv
// Self-checking testbench for the frame admission filter: directed script, then random.
`timescale 1ns / 1ps

module frame_admission_whitelist_replay_test
    import fawr_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         MIN_LEN     = HEADER_BYTES + AUTH_TAG_BYTES_DEF;
    localparam int         PIPE_DEPTH  = NODE_SLOTS_DEF + 2;
    localparam int         SETTLE      = PIPE_DEPTH + 8;
    localparam int         HOLD_CYCLES = 120;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         POOL_MAX    = 24;

    localparam logic [15:0] DIR_OWN   = 16'h00AA;
    localparam logic [15:0] DIR_MAGIC = 16'hA55A;
    localparam logic [7:0]  DIR_ACK   = 8'h0A;
    localparam logic [7:0]  DIR_JOIN  = 8'h0B;
    localparam logic [7:0]  MT_DATA   = 8'h33;

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t verdict;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // Shadow of the configuration registers
    logic [15:0] own_id      = 16'h0000;
    logic [15:0] want_magic  = 16'h0000;
    logic [7:0]  payload_cap = PAYLOAD_LIMIT_RST;
    logic [7:0]  ack_code    = 8'h00;
    logic [7:0]  join_code   = 8'h00;

    // Shadow of the whitelist
    bit [15:0]   slot_id     [NODE_SLOTS_DEF];
    bit          slot_active [NODE_SLOTS_DEF];
    bit [7:0]    slot_seq    [NODE_SLOTS_DEF];
    bit [15:0]   slot_rx     [NODE_SLOTS_DEF];
    int          slots_used = 0;

    out_item_t   verdict_queue[$];
    out_item_t   want;
    step_row_t   script[$];
    bit [15:0]   node_pool[POOL_MAX];
    int          pool_size = 12;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    frame_admission_whitelist_replay u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL frame_admission_whitelist_replay");
            $finish;
        end
    end

    function automatic int slot_of(logic [15:0] id);
        for (int i = 0; i < slots_used && i < NODE_SLOTS_DEF; i++)
        begin
            if (slot_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic bit enroll_node(logic [15:0] id);
        int k;
        if (slots_used >= NODE_SLOTS_DEF)
            return 1'b0;
        k = slot_of(id);
        if (k >= 0)
        begin
            slot_active[k] = 1'b1;
            return 1'b1;
        end
        slot_id[slots_used]     = id;
        slot_active[slots_used] = 1'b1;
        slots_used++;
        return 1'b1;
    endfunction

    // Predict the verdict for one request and advance the shadow state.
    function automatic out_item_t admit_request(in_item_t it);
        out_item_t r;
        int        k;
        r = '0;
        r.status = ST_OK;
        case (it.kind)
            KIND_FRAME:
            begin
                if (int'(it.frame_length) < MIN_LEN)
                    r.status = ST_SHORT;
                else if (it.magic_word != want_magic)
                    r.status = ST_MAGIC;
                else if (it.payload_length > payload_cap)
                    r.status = ST_PAYLOAD;
                else if (MIN_LEN + int'(it.payload_length) > int'(it.frame_length))
                    r.status = ST_TRUNC;
                else
                begin
                    k = slot_of(it.node_id);
                    if (it.node_id != own_id && !(k >= 0 && slot_active[k]))
                        r.status = ST_UNKNOWN;
                    else if (k >= 0 && slot_seq[k] == it.sequence_req)
                        r.status = ST_REPLAY;
                    else
                    begin
                        // sequence and count move before the auth verdict
                        if (k >= 0)
                        begin
                            slot_seq[k] = it.sequence_req;
                            slot_rx[k]  = slot_rx[k] + 16'd1;
                        end
                        if (!it.auth_ok)
                            r.status = ST_AUTH;
                        else if (it.message_type == ack_code)
                            r.ack_recorded = 1'b1;
                        else if (it.message_type == join_code)
                            r.join_added = enroll_node(it.node_id);
                    end
                end
            end
            KIND_ADD:
            begin
                r.status = enroll_node(it.node_id) ? ST_OK : ST_FULL;
            end
            KIND_REMOVE:
            begin
                k = slot_of(it.node_id);
                if (k >= 0)
                    slot_active[k] = 1'b0;
                else
                    r.status = ST_ABSENT;
            end
            default:
            begin
            end
        endcase
        if (it.kind != KIND_UNUSED)
        begin
            k = slot_of(it.node_id);
            if (k >= 0)
                r.sender_rx_count = slot_rx[k];
        end
        return r;
    endfunction

    function automatic step_row_t step_row(logic [1:0] kind, logic [15:0] id,
                                           logic [7:0] flen, logic [15:0] magic,
                                           logic [7:0] seq, logic [7:0] mtype,
                                           logic [7:0] plen, logic auth, bit typed,
                                           logic [3:0] st, logic ack, logic join_v,
                                           logic [15:0] rx);
        step_row_t r;
        r.req.kind                = kind;
        r.req.node_id             = id;
        r.req.frame_length        = flen;
        r.req.magic_word          = magic;
        r.req.sequence_req        = seq;
        r.req.message_type        = mtype;
        r.req.payload_length      = plen;
        r.req.auth_ok             = auth;
        r.typed                   = typed;
        r.verdict.status          = st;
        r.verdict.ack_recorded    = ack;
        r.verdict.join_added      = join_v;
        r.verdict.sender_rx_count = rx;
        return r;
    endfunction

    function automatic logic [15:0] pick_node();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return own_id;
        if (roll == 1)
            return 16'($urandom);
        return node_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    // Mostly well-formed frames from known nodes; some table edits, broken headers, noise.
    function automatic in_item_t make_request();
        in_item_t it;
        int       pick;
        int       roll;
        int       k;
        it = '0;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            it.kind           = KIND_FRAME;
            it.node_id        = pick_node();
            it.magic_word     = want_magic;
            it.payload_length = 8'($urandom_range(0, payload_cap));
            it.frame_length   = 8'($urandom_range(MIN_LEN + int'(it.payload_length), 255));
            k = slot_of(it.node_id);
            if (k >= 0 && $urandom_range(0, 6) == 0)
                it.sequence_req = slot_seq[k];
            else
                it.sequence_req = 8'($urandom);
            roll = $urandom_range(0, 9);
            if (roll < 3)
                it.message_type = ack_code;
            else if (roll < 6)
                it.message_type = join_code;
            else
                it.message_type = 8'($urandom);
            it.auth_ok = ($urandom_range(0, 7) != 0);
            if (pick >= 68)
            begin
                // break one header check
                case ($urandom_range(0, 3))
                    0: it.frame_length = 8'($urandom_range(0, MIN_LEN - 1));
                    1: it.magic_word = want_magic ^ (16'h0001 << $urandom_range(0, 15));
                    2: it.payload_length = 8'($urandom_range(int'(payload_cap) + 1, 255));
                    default:
                    begin
                        if (payload_cap != 0)
                        begin
                            it.payload_length = 8'($urandom_range(1, payload_cap));
                            it.frame_length = 8'($urandom_range(MIN_LEN,
                                                  MIN_LEN + int'(it.payload_length) - 1));
                        end
                        else
                            it.frame_length = 8'($urandom_range(0, MIN_LEN - 1));
                    end
                endcase
            end
        end
        else if (pick < 88)
        begin
            it.kind    = KIND_ADD;
            it.node_id = pick_node();
        end
        else if (pick < 92)
        begin
            it.kind    = KIND_REMOVE;
            it.node_id = pick_node();
        end
        else
        begin
            it.kind           = 2'($urandom_range(0, 3));
            it.node_id        = 16'($urandom);
            it.frame_length   = 8'($urandom);
            it.magic_word     = 16'($urandom);
            it.sequence_req   = 8'($urandom);
            it.message_type   = 8'($urandom);
            it.payload_length = 8'($urandom);
            it.auth_ok        = 1'($urandom);
        end
        return it;
    endfunction

    task automatic send_request(input in_item_t it, input bit typed,
                                input out_item_t typed_verdict);
        out_item_t predicted;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        predicted = admit_request(it);
        verdict_queue.push_back(typed ? typed_verdict : predicted);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_OWN_NODE_ID:    own_id      = data;
            CFG_EXPECTED_MAGIC: want_magic  = data;
            CFG_PAYLOAD_LIMIT:  payload_cap = data[7:0];
            CFG_ACK_TYPE_CODE:  ack_code    = data[7:0];
            CFG_JOIN_TYPE_CODE: join_code   = data[7:0];
            default: ;
        endcase
    endtask

    // Drain all results, let the row settle, then reprogram every register.
    task automatic apply_settings(input logic [15:0] own, input logic [15:0] magic,
                                  input logic [7:0] limit, input logic [7:0] ack,
                                  input logic [7:0] join_c);
        in_valid <= 1'b0;
        while (verdict_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_reg(CFG_OWN_NODE_ID, own);
        write_reg(CFG_EXPECTED_MAGIC, magic);
        write_reg(CFG_PAYLOAD_LIMIT, {8'h00, limit});
        write_reg(CFG_ACK_TYPE_CODE, {8'h00, ack});
        write_reg(CFG_JOIN_TYPE_CODE, {8'h00, join_c});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            send_request(make_request(), 1'b0, '0);
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_queue.size() == 0)
            begin
                $error("result with no request pending: status %0d", out_item.status);
                fail_count++;
            end
            else
            begin
                want = verdict_queue.pop_front();
                check_field("status", 16'(want.status), 16'(out_item.status));
                check_field("ack_recorded", 16'(want.ack_recorded),
                            16'(out_item.ack_recorded));
                check_field("join_added", 16'(want.join_added), 16'(out_item.join_added));
                check_field("sender_rx_count", want.sender_rx_count,
                            out_item.sender_rx_count);
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_OWN_NODE_ID;
        cfg_data  <= 16'h0000;
        node_pool[0] = 16'h0010;
        node_pool[1] = DIR_OWN;
        node_pool[2] = 16'hFFFF;
        node_pool[3] = 16'h0000;
        node_pool[4] = 16'h0020;
        for (int i = 5; i < POOL_MAX; i++)
            node_pool[i] = 16'($urandom);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings(DIR_OWN, DIR_MAGIC, PAYLOAD_LIMIT_RST, DIR_ACK, DIR_JOIN);

        script.push_back(step_row(KIND_REMOVE, 16'h0010, 8'd0, 16'h0000, 8'd0, 8'd0, 8'd0,
                                  1'b0, 1'b1, ST_ABSENT, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd40, DIR_MAGIC, 8'd1, MT_DATA, 8'd0,
                                  1'b1, 1'b1, ST_SHORT, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0000, 8'd0, 16'h0000, 8'd0, 8'd0, 8'd0,
                                  1'b0, 1'b1, ST_SHORT, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd255, 16'h0000, 8'd1, MT_DATA,
                                  8'd0, 1'b1, 1'b1, ST_MAGIC, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd255, DIR_MAGIC, 8'd1, MT_DATA,
                                  8'd215, 1'b1, 1'b1, ST_PAYLOAD, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'hFFFF, 8'd255, DIR_MAGIC, 8'hFF, 8'hFF,
                                  8'd255, 1'b1, 1'b1, ST_PAYLOAD, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd50, DIR_MAGIC, 8'd1, MT_DATA,
                                  8'd10, 1'b1, 1'b1, ST_TRUNC, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd255, DIR_MAGIC, 8'd1, MT_DATA,
                                  8'd214, 1'b1, 1'b1, ST_UNKNOWN, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, DIR_OWN, 8'd41, DIR_MAGIC, 8'd0, MT_DATA,
                                  8'd0, 1'b1, 1'b1, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, DIR_OWN, 8'd41, DIR_MAGIC, 8'd0, MT_DATA,
                                  8'd0, 1'b0, 1'b1, ST_AUTH, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_ADD, 16'h0010, 8'd0, 16'h0000, 8'd0, 8'd0, 8'd0,
                                  1'b0, 1'b1, ST_OK, 1'b0, 1'b0, 16'd0));
        // fresh entry holds sequence zero, so a zero sequence replays
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd255, DIR_MAGIC, 8'd0, MT_DATA,
                                  8'd0, 1'b1, 1'b1, ST_REPLAY, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd255, DIR_MAGIC, 8'd1, MT_DATA,
                                  8'd0, 1'b0, 1'b1, ST_AUTH, 1'b0, 1'b0, 16'd1));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd255, DIR_MAGIC, 8'd1, MT_DATA,
                                  8'd0, 1'b1, 1'b1, ST_REPLAY, 1'b0, 1'b0, 16'd1));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd255, DIR_MAGIC, 8'd2, DIR_ACK,
                                  8'd0, 1'b1, 1'b1, ST_OK, 1'b1, 1'b0, 16'd2));
        script.push_back(step_row(KIND_REMOVE, 16'h0010, 8'd0, 16'h0000, 8'd0, 8'd0, 8'd0,
                                  1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd255, DIR_MAGIC, 8'd3, MT_DATA,
                                  8'd0, 1'b1, 1'b0, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_ADD, 16'h0010, 8'd0, 16'h0000, 8'd0, 8'd0, 8'd0,
                                  1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0010, 8'd255, DIR_MAGIC, 8'd4, DIR_JOIN,
                                  8'd0, 1'b1, 1'b0, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'h0020, 8'd255, DIR_MAGIC, 8'd1, DIR_JOIN,
                                  8'd0, 1'b1, 1'b1, ST_UNKNOWN, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, DIR_OWN, 8'd255, DIR_MAGIC, 8'd7, DIR_JOIN,
                                  8'd0, 1'b1, 1'b0, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, DIR_OWN, 8'd255, DIR_MAGIC, 8'd0, MT_DATA,
                                  8'd0, 1'b1, 1'b0, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
                                  1'b1, 1'b1, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_ADD, 16'hFFFF, 8'd0, 16'h0000, 8'd0, 8'd0, 8'd0,
                                  1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_REMOVE, 16'hFFFF, 8'd0, 16'h0000, 8'd0, 8'd0, 8'd0,
                                  1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_FRAME, 16'hFFFF, 8'd255, DIR_MAGIC, 8'd9, MT_DATA,
                                  8'd0, 1'b1, 1'b1, ST_UNKNOWN, 1'b0, 1'b0, 16'd0));
        script.push_back(step_row(KIND_ADD, 16'h0000, 8'd0, 16'h0000, 8'd0, 8'd0, 8'd0,
                                  1'b0, 1'b0, ST_OK, 1'b0, 1'b0, 16'd0));
        foreach (script[i])
            send_request(script[i].req, script[i].typed, script[i].verdict);

        // ack and join codes equal: acknowledgement wins
        apply_settings(16'h0000, 16'h0000, PAYLOAD_LIMIT_RST, 8'h00, 8'h00);
        run_random(450, 100);
        apply_settings(16'hFFFF, 16'hFFFF, 8'd0, 8'hFF, 8'h00);
        run_random(450, -1);
        apply_settings(16'($urandom), 16'($urandom), 8'($urandom_range(0, 214)),
                       8'($urandom), 8'($urandom));
        run_random(450, -1);

        // widen the node pool so the table fills up
        pool_size = POOL_MAX;
        apply_settings(DIR_OWN, DIR_MAGIC, PAYLOAD_LIMIT_RST, DIR_ACK, DIR_JOIN);
        run_random(250, -1);
        idle_en = 1'b0;
        run_random(200, -1);
        in_valid <= 1'b0;

        while (verdict_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("PASS frame_admission_whitelist_replay");
        else
            $display("FAIL frame_admission_whitelist_replay");
        $finish;
    end

endmodule
